// ===== sv/bounded_sorted_top_k_table_defines.svh =====
`ifndef BOUNDED_SORTED_TOP_K_TABLE_DEFINES_SVH
`define BOUNDED_SORTED_TOP_K_TABLE_DEFINES_SVH

// implication checked in the same cycle
`define BSTK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bstk check failed");

// implication checked in the cycle after the antecedent
`define BSTK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bstk check failed");

`endif

// ===== sv/bstk_pkg.sv =====
`timescale 1ns / 1ps

package bstk_pkg;

    localparam int TABLE_SIZE = 8;
    localparam int NAME_CHARS = 3;

    localparam int SCORE_W = 24;
    localparam int NAME_W  = 24;
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);

    localparam logic [SCORE_W-1:0] SCORE_MAX = 24'd9999999;
    localparam logic [NAME_W-1:0]  NAME_MASK = (NAME_CHARS >= 3) ? 24'hFFFFFF
                                             : 24'((64'd1 << (8 * NAME_CHARS)) - 64'd1);

    localparam logic [1:0] REQ_OFFER = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
    } entry_t;

    // handed from each cell to the one below it
    typedef struct packed {
        logic lower;
        logic occ;
    } link_t;

endpackage

// ===== sv/bounded_sorted_top_k_table.sv =====
`timescale 1ns / 1ps

// Sorted top-k table built as a row of cells, highest score in cell 0. Each cell compares
// its own score with an offer and decides locally whether to take the offer, take its upper
// neighbor's entry or hold, with no request waiting on the one before: a request taken at an
// edge (start high, busy low) produces its result with done high for exactly one cycle right
// after that edge. busy never rises, so one request per cycle is sustained. The result cannot
// be stalled and must be captured while done is high; entry_count and top_score show the
// table after the request.
module bounded_sorted_top_k_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [23:0] offer_score,
    input  logic [23:0] offer_name,
    input  logic [2:0]  read_index,
    output logic        done,
    output logic        accepted,
    output logic [2:0]  insert_position,
    output logic        entry_valid,
    output logic [23:0] entry_name,
    output logic [23:0] entry_score,
    output logic [3:0]  entry_count,
    output logic [23:0] top_score
);

    localparam int N = bstk_pkg::TABLE_SIZE;

    logic                       req_fire;
    logic                       offer;
    bstk_pkg::entry_t           offer_entry;
    bstk_pkg::link_t            link [0:N];
    bstk_pkg::entry_t           entry [0:N];
    bstk_pkg::entry_t           entry_next [0:N-1];
    logic [N-1:0]               ins;
    logic [N-1:0]               occ;

    logic [bstk_pkg::CNT_W-1:0] count_reg;
    logic [bstk_pkg::CNT_W-1:0] count_next;

    logic                       done_reg;
    logic                       accepted_reg;
    logic                       accepted_next;
    logic [2:0]                 pos_reg;
    logic [2:0]                 pos_next;
    logic                       valid_reg;
    logic                       valid_next;
    bstk_pkg::entry_t           rd_reg;
    bstk_pkg::entry_t           rd_next;
    logic [3:0]                 cnt_out_reg;
    logic [23:0]                high_reg;
    logic [23:0]                high_next;

    assign busy     = 1'b0;
    assign req_fire = start && !busy;
    assign offer    = req_fire && (req_type == bstk_pkg::REQ_OFFER);

    assign offer_entry.score = (offer_score > bstk_pkg::SCORE_MAX) ? bstk_pkg::SCORE_MAX
                                                                   : offer_score;
    assign offer_entry.name  = offer_name & bstk_pkg::NAME_MASK;

    // boundary above cell 0: counts as filled and not lower
    assign link[0].lower = 1'b0;
    assign link[0].occ   = 1'b1;
    assign entry[0]      = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            bstk_pkg::entry_t cell_entry;

            assign occ[g] = (bstk_pkg::CNT_W'(g) < count_reg);

            bstk_cell u_cell (
                .clk         (clk),
                .offer       (offer),
                .offer_entry (offer_entry),
                .occ         (occ[g]),
                .prev_link   (link[g]),
                .prev_entry  (g == 0 ? entry[0] : entry[g]),
                .link        (link[g+1]),
                .entry       (cell_entry),
                .entry_next  (entry_next[g]),
                .ins         (ins[g])
            );

            assign entry[g+1] = cell_entry;
        end
    endgenerate

    // entry[g+1] holds cell g
    always_comb
    begin
        accepted_next = |ins;
        pos_next      = '0;
        valid_next    = 1'b0;
        rd_next       = '0;
        for (int i = 0; i < N; i++)
        begin
            if (ins[i])
            begin
                pos_next = pos_next | 3'(i);
            end
            if ((req_type == bstk_pkg::REQ_READ) && occ[i] && (32'(read_index) == i))
            begin
                valid_next = 1'b1;
                rd_next    = entry[i+1];
            end
        end

        count_next = count_reg;
        case (req_type)
            bstk_pkg::REQ_OFFER:
            begin
                if (accepted_next && (count_reg < bstk_pkg::CNT_W'(N)))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            bstk_pkg::REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (!req_fire)
        begin
            count_next = count_reg;
        end

        // table stays sorted, so the top score is cell 0
        high_next = (count_next != '0) ? entry_next[0].score : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= req_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            accepted_reg <= accepted_next;
            pos_reg      <= pos_next;
            valid_reg    <= valid_next;
            rd_reg       <= rd_next;
            cnt_out_reg  <= 4'(count_next);
            high_reg     <= high_next;
        end
    end

    assign done            = done_reg;
    assign accepted        = accepted_reg;
    assign insert_position = pos_reg;
    assign entry_valid     = valid_reg;
    assign entry_name      = rd_reg.name;
    assign entry_score     = rd_reg.score;
    assign entry_count     = cnt_out_reg;
    assign top_score       = high_reg;

endmodule

// ===== sv/bstk_cell.sv =====
`timescale 1ns / 1ps

module bstk_cell (
    input  logic            clk,
    input  logic            offer,
    input  bstk_pkg::entry_t offer_entry,
    input  logic            occ,
    input  bstk_pkg::link_t  prev_link,
    input  bstk_pkg::entry_t prev_entry,
    output bstk_pkg::link_t  link,
    output bstk_pkg::entry_t entry,
    output bstk_pkg::entry_t entry_next,
    output logic            ins
);

    bstk_pkg::entry_t entry_reg;
    logic             lower;
    logic             first_lower;
    logic             append;
    logic             shift;

    assign lower       = occ && (entry_reg.score < offer_entry.score);
    assign first_lower = lower && !prev_link.lower;
    // first empty cell, nothing above was lower, and the score is nonzero
    assign append      = !occ && prev_link.occ && !prev_link.lower
                         && (offer_entry.score != '0);
    assign ins         = offer && (first_lower || append);
    assign shift       = offer && prev_link.lower;

    always_comb
    begin
        if (ins)
        begin
            entry_next = offer_entry;
        end
        else if (shift)
        begin
            entry_next = prev_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.lower = lower;
    assign link.occ   = occ;
    assign entry      = entry_reg;

endmodule

// ===== sv/bstk_checker.sv =====
`timescale 1ns / 1ps
`include "bounded_sorted_top_k_table_defines.svh"

module bstk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        accepted,
    input logic        entry_valid,
    input logic [23:0] entry_name,
    input logic [23:0] entry_score,
    input logic [3:0]  entry_count,
    input logic [23:0] top_score
);

    `BSTK_ASSERT_NEXT(a_req_gives_result, start && !busy, done)
    `BSTK_ASSERT_NOW(a_result_has_req, done, $past(start && !busy))
    `BSTK_ASSERT_NOW(a_accept_nonempty, done && accepted, entry_count != 4'd0 && top_score != 24'd0)
    `BSTK_ASSERT_NOW(a_empty_no_top, done && entry_count == 4'd0, top_score == 24'd0)
    `BSTK_ASSERT_NOW(a_invalid_read_zero, done && !entry_valid, entry_name == 24'd0 && entry_score == 24'd0)

endmodule

bind bounded_sorted_top_k_table bstk_checker u_bstk_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bstk_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [23:0] offer_score;
    logic [23:0] offer_name;
    logic [2:0]  read_index;
    logic        done;
    logic        accepted;
    logic [2:0]  insert_position;
    logic        entry_valid;
    logic [23:0] entry_name;
    logic [23:0] entry_score;
    logic [3:0]  entry_count;
    logic [23:0] top_score;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  insert_position;
        logic        entry_valid;
        logic [23:0] entry_name;
        logic [23:0] entry_score;
        logic [3:0]  entry_count;
        logic [23:0] top_score;
    } table_answer_t;

    class score_table_model;
        logic [23:0]   slot_score [TABLE_SIZE];
        logic [23:0]   slot_name  [TABLE_SIZE];
        int unsigned   fill;
        table_answer_t awaited[$];
        int unsigned   errors;

        function new();
            fill   = 0;
            errors = 0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_score[i] = '0;
                slot_name[i]  = '0;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // update the table as the block should and queue its answer
        function void apply_request(input logic [1:0] kind, input logic [23:0] score,
                                    input logic [23:0] name, input logic [2:0] idx);
            table_answer_t ans;
            logic [23:0]   sat;
            logic [23:0]   top;
            int            pos;
            bit            found;
            ans   = '0;
            found = 0;
            pos   = 0;
            case (kind)
                REQ_OFFER:
                begin
                    sat = (score > SCORE_MAX) ? SCORE_MAX : score;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (!found && slot_score[i] < sat)
                        begin
                            pos   = i;
                            found = 1;
                        end
                    end
                    // nothing lower: append if there is room and the score counts
                    if (!found && sat != 0 && fill < TABLE_SIZE)
                    begin
                        pos   = fill;
                        found = 1;
                    end
                    if (found)
                    begin
                        if (fill < TABLE_SIZE)
                            fill++;
                        for (int i = fill - 1; i > pos; i--)
                        begin
                            slot_score[i] = slot_score[i-1];
                            slot_name[i]  = slot_name[i-1];
                        end
                        slot_score[pos]     = sat;
                        slot_name[pos]      = name & NAME_MASK;
                        ans.accepted        = 1'b1;
                        ans.insert_position = 3'(pos);
                    end
                end
                REQ_READ:
                begin
                    if (idx < fill)
                    begin
                        ans.entry_valid = 1'b1;
                        ans.entry_name  = slot_name[idx];
                        ans.entry_score = slot_score[idx];
                    end
                end
                REQ_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            top = '0;
            for (int i = 0; i < fill; i++)
                if (slot_score[i] > top)
                    top = slot_score[i];
            ans.entry_count = 4'(fill);
            ans.top_score   = top;
            awaited.push_back(ans);
        endfunction

        function void report(input string field, input logic [23:0] want,
                             input logic [23:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(input table_answer_t got);
            table_answer_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding, expected none, actual %p",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            if (got.accepted !== want.accepted)
                report("accepted", want.accepted, got.accepted);
            if (got.insert_position !== want.insert_position)
                report("insert_position", want.insert_position, got.insert_position);
            if (got.entry_valid !== want.entry_valid)
                report("entry_valid", want.entry_valid, got.entry_valid);
            if (got.entry_name !== want.entry_name)
                report("entry_name", want.entry_name, got.entry_name);
            if (got.entry_score !== want.entry_score)
                report("entry_score", want.entry_score, got.entry_score);
            if (got.entry_count !== want.entry_count)
                report("entry_count", want.entry_count, got.entry_count);
            if (got.top_score !== want.top_score)
                report("top_score", want.top_score, got.top_score);
        endfunction

        function void check_drained();
            if (awaited.size() != 0)
            begin
                errors++;
                $display("%0t: results missing, expected %0d more, actual 0",
                         $time, awaited.size());
            end
        endfunction
    endclass

    score_table_model table_model;
    int unsigned      idle_pct;
    int unsigned      stall_cycles;

    bounded_sorted_top_k_table uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .offer_score     (offer_score),
        .offer_name      (offer_name),
        .read_index      (read_index),
        .done            (done),
        .accepted        (accepted),
        .insert_position (insert_position),
        .entry_valid     (entry_valid),
        .entry_name      (entry_name),
        .entry_score     (entry_score),
        .entry_count     (entry_count),
        .top_score       (top_score)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            table_model.check_result('{accepted, insert_position, entry_valid, entry_name,
                                       entry_score, entry_count, top_score});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_request(input logic [1:0] kind, input logic [23:0] score,
                                input logic [23:0] name, input logic [2:0] idx);
        bit taken;
        taken = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        req_type    <= kind;
        offer_score <= score;
        offer_name  <= name;
        read_index  <= idx;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1;
                table_model.apply_request(kind, score, name, idx);
            end
        end
    endtask

    task automatic offer(input logic [23:0] score);
        send_request(REQ_OFFER, score, 24'($urandom), 3'($urandom));
    endtask

    // hold off new requests until every answer is back
    task automatic drain_table();
        @(negedge clk);
        start <= 1'b0;
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_score();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return 24'($urandom_range(15));
        else if (r < 70)
            return 24'($urandom_range(SCORE_MAX, 1));
        else if (r < 85)
            return 24'($urandom);
        else
            return SCORE_MAX - 24'($urandom_range(3));
    endfunction

    task automatic random_phase(input int unsigned count);
        int unsigned r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                send_request(REQ_CLEAR, 24'($urandom), 24'($urandom), 3'($urandom));
            else if (r < 6)
                send_request(REQ_SPARE, 24'($urandom), 24'($urandom), 3'($urandom));
            else if (r < 30)
                send_request(REQ_READ, 24'($urandom), 24'($urandom), 3'($urandom));
            else
                offer(pick_score());
        end
    endtask

    initial
    begin
        table_model  = new();
        idle_pct     = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_OFFER;
        offer_score  = '0;
        offer_name   = '0;
        read_index   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: reads miss and a zero score is turned away
        send_request(REQ_READ, 24'd0, 24'd0, 3'd0);
        send_request(REQ_READ, 24'hFFFFFF, 24'hFFFFFF, 3'd7);
        offer(24'd0);
        // saturation, then ties at the top and at the bottom
        send_request(REQ_OFFER, 24'hFFFFFF, 24'hFFFFFF, 3'd0);
        send_request(REQ_OFFER, SCORE_MAX, 24'h000000, 3'd7);
        offer(24'd1);
        offer(24'd1);
        offer(24'd500);
        offer(24'h800000);
        offer(24'd300);
        offer(24'd20);
        // full table: zero and an equal-to-last score are rejected
        offer(24'd0);
        offer(24'd1);
        offer(24'd2);
        offer(SCORE_MAX + 24'd1);
        send_request(REQ_SPARE, 24'd77, 24'd77, 3'd3);
        for (int i = 0; i < TABLE_SIZE; i++)
            send_request(REQ_READ, 24'($urandom), 24'($urandom), 3'(i));
        send_request(REQ_CLEAR, 24'($urandom), 24'($urandom), 3'd0);
        send_request(REQ_READ, 24'($urandom), 24'($urandom), 3'd0);
        drain_table();

        idle_pct = 35;
        random_phase(260);
        drain_table();
        idle_pct = 78;
        random_phase(260);
        drain_table();
        idle_pct = 0;
        random_phase(260);
        drain_table();

        table_model.check_drained();
        if (table_model.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bstk_pkg.sv
sv/bstk_cell.sv
sv/bounded_sorted_top_k_table.sv
sv/bstk_checker.sv
sim/tb_top.sv
